FILE: design/uths_pkg.sv
// ----------------------------------------------------------------------------
// uths_pkg: shared constants and angle helpers
// Codes, timing limits and centidegree wrap functions for the upwind tack
// heading selector.
// ----------------------------------------------------------------------------
package uths_pkg;

  // Item modes
  localparam logic MODE_NAV     = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_GO    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CORRIDOR = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOTOR    = 2'd2;
  localparam int unsigned CFG_DATA_W = 12;

  // Motor policy codes
  localparam logic [1:0] MOTOR_NEVER  = 2'd0;
  localparam logic [1:0] MOTOR_ASSIST = 2'd1;
  localparam logic [1:0] MOTOR_ALWAYS = 2'd2;

  // Configuration reset values
  localparam logic [6:0]  NO_GO_RESET    = 7'd45;
  localparam logic [11:0] CORRIDOR_RESET = 12'd1000;
  localparam logic [1:0]  MOTOR_RESET    = MOTOR_ASSIST;

  // Timing limits in milliseconds
  localparam logic [31:0] TACK_TIMEOUT_MS      = 32'd5000;
  localparam logic [31:0] TACK_RETRY_MS        = 32'd5000;
  localparam logic [31:0] TACK_ASSIST_LIMIT_MS = 32'd15000;
  localparam logic [31:0] REQUEST_WINDOW_MS    = 32'd500;

  // Angles in centidegrees
  localparam logic [15:0]        FULL_TURN_U    = 16'd36000;
  localparam logic signed [17:0] FULL_TURN_S    = 18'sd36000;
  localparam logic signed [17:0] HALF_TURN_S    = 18'sd18000;
  localparam logic signed [15:0] TACK_ACCURACY  = 16'sd1000;
  localparam logic [17:0]        HALF_TURN_U18  = 18'd18000;
  localparam logic [13:0]        DEG_TO_CD      = 14'd100;

  // Reduce a raw 16-bit heading into [0, 36000)
  function automatic logic [15:0] wrap_heading(input logic [15:0] h);
    return (h >= FULL_TURN_U) ? (h - FULL_TURN_U) : h;
  endfunction

  // Wrap a difference in (-36000, 36000) into (-18000, 18000]
  function automatic logic signed [15:0] wrap_half(input logic signed [17:0] d);
    logic signed [17:0] r;
    r = d;
    if (r < 18'sd0) begin
      r = r + FULL_TURN_S;
    end
    if (r > HALF_TURN_S) begin
      r = r - FULL_TURN_S;
    end
    return r[15:0];
  endfunction

  // Yaw within tack accuracy of the target
  function automatic logic near_target(input logic [15:0] tgt, input logic [15:0] yaw);
    logic signed [17:0] d;
    logic signed [15:0] h;
    logic signed [15:0] a;
    d = $signed({2'b00, tgt}) - $signed({2'b00, yaw});
    h = wrap_half(d);
    a = h[15] ? -h : h;
    return a <= TACK_ACCURACY;
  endfunction

endpackage

FILE: design/upwind_tack_heading_selector_unit.sv
// ----------------------------------------------------------------------------
// upwind_tack_heading_selector_unit
// Chooses the steering heading for upwind sailing and runs the tack sequence.
// ----------------------------------------------------------------------------
// Each accepted item is a navigation step (mode 0) or a user tack request
// (mode 1). A navigation step returns exactly one result (target heading,
// tacking flag, motor-assist flag); a request returns nothing and only arms
// the request time. The block takes one item every clock cycle while the result
// side does not stall: an item is captured into the input register, its tack
// decision and state update are evaluated while it sits there, and its result
// is loaded into the result register as it leaves. The state (tacking flag, target,
// request, start and clear times, assist flag) updates as each item leaves
// the input register, so consecutive items see each other's effect in order.
// The only pause comes from the result side: while a result waits under
// stall, the input register holds and item_stall rises once it is full.
// Angles are integer centidegrees wrapped into [0, 36000); time differences
// wrap at 32 bits. Configuration writes are taken any cycle but are meant to
// land only while the block is idle.
module upwind_tack_heading_selector_unit
  import uths_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  // input channel
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   mode,
  input  logic [31:0]            now_ms,
  input  logic                   sailing_allowed,
  input  logic [15:0]            wanted_course_cd,
  input  logic [15:0]            true_wind_cd,
  input  logic signed [15:0]     apparent_wind_cd,
  input  logic [15:0]            heading_now_cd,
  input  logic                   on_starboard,
  input  logic signed [20:0]     crosstrack_cm,
  // result channel
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [15:0]            target_heading_cd,
  output logic                   is_tacking,
  output logic                   assist_motor
);

  // Configuration registers
  logic [6:0]  no_go_deg;
  logic [11:0] corridor_cm;
  logic [1:0]  motor_use;

  // Tack state
  logic        tacking;
  logic        assist_flag;
  logic [15:0] tack_target_cd;
  logic [31:0] request_time;
  logic [31:0] clear_time;
  logic [31:0] start_time;

  logic        tacking_next;
  logic        assist_flag_next;
  logic [15:0] tack_target_cd_next;
  logic [31:0] request_time_next;
  logic [31:0] clear_time_next;
  logic [31:0] start_time_next;

  // Input register (headings already reduced into range)
  logic               s1_valid;
  logic               s1_mode;
  logic [31:0]        s1_now;
  logic               s1_allowed;
  logic [15:0]        s1_desired;
  logic [15:0]        s1_wind;
  logic signed [15:0] s1_app;
  logic [15:0]        s1_yaw;
  logic               s1_starboard;
  logic signed [20:0] s1_xte;

  // Result next values
  logic [15:0] heading_next;
  logic        is_tacking_next;
  logic        assist_motor_next;

  logic accept;
  logic advance;

  // Hold the input register while a finished result waits under stall.
  assign advance    = s1_valid && !(result_valid && result_stall);
  assign item_stall = s1_valid && result_valid && result_stall;
  assign accept     = item_valid && !item_stall;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      no_go_deg   <= NO_GO_RESET;
      corridor_cm <= CORRIDOR_RESET;
      motor_use   <= MOTOR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_NO_GO:    no_go_deg   <= wr_data[6:0];
        CFG_CORRIDOR: corridor_cm <= wr_data;
        CFG_MOTOR:    motor_use   <= wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode      <= mode;
      s1_now       <= now_ms;
      s1_allowed   <= sailing_allowed;
      s1_desired   <= wrap_heading(wanted_course_cd);
      s1_wind      <= wrap_heading(true_wind_cd);
      s1_app       <= apparent_wind_cd;
      s1_yaw       <= wrap_heading(heading_now_cd);
      s1_starboard <= on_starboard;
      s1_xte       <= crosstrack_cm;
    end
  end

  // Step evaluation
  logic [13:0]        no_go_cd;
  logic signed [15:0] rel;
  logic [14:0]        abs_rel;
  logic [16:0]        abs_app;
  logic [17:0]        wind_sum;
  logic [17:0]        app_rel_sum;
  logic [21:0]        abs_xte;
  logic [15:0]        left_cd;
  logic [15:0]        right_cd;
  logic signed [17:0] right_raw;
  logic               outside_no_go;
  logic               cross_tack;
  logic               early_out;
  logic               want_tack;
  logic               start_tack;
  logic               xte_pos;
  logic               xte_neg;
  logic [15:0]        eff_target;
  logic               eff_near;
  logic [31:0]        elapsed;
  logic               timed_out;

  always_comb begin
    no_go_cd  = 14'(no_go_deg) * DEG_TO_CD;

    rel       = wrap_half($signed({2'b00, s1_wind}) - $signed({2'b00, s1_desired}));
    abs_rel   = rel[15] ? 15'(-rel) : rel[14:0];
    abs_app   = s1_app[15] ? (17'd0 - 17'($signed(s1_app))) : {1'b0, s1_app};
    app_rel_sum = 18'(abs_app) + 18'(abs_rel);

    // No-go edges either side of the wind
    wind_sum  = {2'b00, s1_wind} + {4'b0000, no_go_cd};
    left_cd   = (wind_sum >= 18'(FULL_TURN_U)) ? 16'(wind_sum - 18'(FULL_TURN_U))
                                                : wind_sum[15:0];
    right_raw = $signed({2'b00, s1_wind}) - $signed({4'b0000, no_go_cd});
    right_cd  = (right_raw < 18'sd0) ? 16'(right_raw + FULL_TURN_S) : right_raw[15:0];

    abs_xte   = s1_xte[20] ? (22'd0 - 22'($signed(s1_xte))) : {1'b0, s1_xte};
    xte_pos   = !s1_xte[20] && (s1_xte != 21'sd0);
    xte_neg   = s1_xte[20];

    // Course change through the wind
    outside_no_go = (abs_rel > 15'(no_go_cd));
    cross_tack    = ((!rel[15]) != s1_starboard) && (app_rel_sum < HALF_TURN_U18);
    early_out     = !tacking && outside_no_go && !cross_tack;
    want_tack     = !tacking && outside_no_go && cross_tack;

    tacking_next        = tacking;
    assist_flag_next    = assist_flag;
    tack_target_cd_next = tack_target_cd;
    request_time_next   = request_time;
    clear_time_next     = clear_time;
    start_time_next     = start_time;
    heading_next        = s1_desired;
    start_tack          = 1'b0;
    eff_target          = tack_target_cd;
    eff_near            = 1'b0;
    elapsed             = 32'd0;
    timed_out           = 1'b0;

    if (s1_mode == MODE_REQUEST) begin
      // Arm the request only when no tack is running
      if (s1_allowed && !tacking) begin
        request_time_next = s1_now;
      end
    end else if (s1_allowed && !early_out) begin
      // Recent user request; consume it
      if ((request_time != 32'd0) && !want_tack && !tacking) begin
        want_tack         = ((s1_now - request_time) < REQUEST_WINDOW_MS);
        request_time_next = 32'd0;
      end

      // Corridor exceeded on the side the current tack heads toward
      if ((corridor_cm != 12'd0) && (abs_xte >= 22'(corridor_cm)) && !want_tack && !tacking)
      begin
        if ((xte_pos && s1_starboard) || (xte_neg && !s1_starboard)) begin
          want_tack = 1'b1;
        end
      end

      start_tack = want_tack && ((s1_now - clear_time) > TACK_RETRY_MS);

      if (start_tack) begin
        eff_target          = s1_starboard ? left_cd : right_cd;
        tack_target_cd_next = eff_target;
        start_time_next     = s1_now;
        elapsed             = 32'd0;
        eff_near            = s1_starboard ? near_target(left_cd, s1_yaw)
                                           : near_target(right_cd, s1_yaw);
      end else begin
        elapsed  = s1_now - start_time;
        eff_near = near_target(tack_target_cd, s1_yaw);
      end
      timed_out = (elapsed > TACK_TIMEOUT_MS);

      if (tacking || start_tack) begin
        tacking_next = 1'b1;
        if (eff_near) begin
          // Target reached: clear the tack
          tacking_next      = 1'b0;
          assist_flag_next  = 1'b0;
          request_time_next = 32'd0;
          clear_time_next   = s1_now;
        end else if (timed_out) begin
          if ((motor_use == MOTOR_ASSIST) && (elapsed < TACK_ASSIST_LIMIT_MS)) begin
            assist_flag_next = 1'b1;
          end else begin
            // Give up on the tack
            tacking_next      = 1'b0;
            assist_flag_next  = 1'b0;
            request_time_next = 32'd0;
            clear_time_next   = s1_now;
          end
        end
        heading_next = eff_target;
      end else begin
        heading_next = s1_starboard ? right_cd : left_cd;
      end
    end

    is_tacking_next   = s1_allowed && tacking_next;
    assist_motor_next = (motor_use == MOTOR_ASSIST) && assist_flag_next;
  end

  // State update as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      tacking        <= 1'b0;
      assist_flag    <= 1'b0;
      tack_target_cd <= 16'd0;
      request_time   <= 32'd0;
      clear_time     <= 32'd0;
      start_time     <= 32'd0;
    end else if (advance) begin
      tacking        <= tacking_next;
      assist_flag    <= assist_flag_next;
      tack_target_cd <= tack_target_cd_next;
      request_time   <= request_time_next;
      clear_time     <= clear_time_next;
      start_time     <= start_time_next;
    end
  end

  // Result register: load on navigation steps, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= (s1_mode == MODE_NAV);
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (s1_mode == MODE_NAV)) begin
      target_heading_cd <= heading_next;
      is_tacking        <= is_tacking_next;
      assist_motor      <= assist_motor_next;
    end
  end

`ifndef SYNTHESIS
  // Assist is only ever held during a running tack.
  a_assist_in_tack: assert property (@(posedge clk) disable iff (rst)
    assist_flag |-> tacking)
    else $error("assist flag set without a running tack");

  // A stored tack target is always a wrapped heading.
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    tacking |-> (tack_target_cd < FULL_TURN_U))
    else $error("tack target out of heading range");

  // Every delivered heading is wrapped.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (target_heading_cd < FULL_TURN_U))
    else $error("result heading out of range");

  // A request item never produces a result.
  a_request_silent: assert property (@(posedge clk) disable iff (rst)
    (advance && (s1_mode == MODE_REQUEST)) |=> !result_valid || $past(result_valid))
    else $error("request item produced a result");
`endif

endmodule
